[sv/skt_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package skt_pkg;

   localparam int CAPACITY_DEFAULT = 64;
   localparam int KEY_BITS_DEFAULT = 32;
   localparam int REQ_KEY_W        = 32;
   localparam int RSP_POS_W        = 7;

   localparam logic [1:0] FUNC_INSERT = 2'd0;
   localparam logic [1:0] FUNC_DELETE = 2'd1;
   localparam logic [1:0] FUNC_SEARCH = 2'd2;

   typedef enum logic [2:0] {
      STATUS_OK       = 3'd0,
      STATUS_DUP      = 3'd1,
      STATUS_FULL     = 3'd2,
      STATUS_NOTFOUND = 3'd3,
      STATUS_EMPTY    = 3'd4
   } skt_status_type;

   // Completion of one request, from the sequencer to the response side.
   typedef struct packed {
      logic           fire;
      skt_status_type status;
      logic           inc;
      logic           dec;
   } skt_done_type;

endpackage

`default_nettype wire

[sv/sorted_key_table.sv]
`timescale 1ns / 1ps
`default_nettype none

// Sorted key table: holds up to CAPACITY distinct signed keys in ascending
// order in one memory and serves one insert, delete or search request at a
// time. A request is taken when start is high and busy is low. The block
// scans the memory from the bottom, reading and comparing each key below the
// requested one, then moves keys one place, each read and then written, to
// open or close a gap; the single read port of the key memory sets that pace.
// A request keeps busy high until it resolves, and its response appears on
// the rsp_ ports for exactly one cycle, marked by rsp_valid, in the cycle
// after the sequencer finishes. The response cannot be held off. No clearing
// pass is needed after reset.

module sorted_key_table #(
   parameter int CAPACITY = skt_pkg::CAPACITY_DEFAULT,
   parameter int KEY_BITS = skt_pkg::KEY_BITS_DEFAULT
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 start,
   output logic                                      busy,
   input  wire logic [1:0]                           req_func,
   input  wire logic signed [skt_pkg::REQ_KEY_W-1:0] req_key,
   output logic                                      rsp_valid,
   output logic      [2:0]                           rsp_status,
   output logic      [skt_pkg::RSP_POS_W-1:0]        rsp_position,
   output logic      [skt_pkg::RSP_POS_W-1:0]        rsp_entry_count
);

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int IDX_W = $clog2(CAPACITY);

   skt_pkg::skt_done_type done;
   logic [CNT_W-1:0]      done_pos;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic                  rsp_valid_ff;
   logic [2:0]            rsp_status_ff;
   logic [CNT_W-1:0]      rsp_pos_ff;
   logic [CNT_W-1:0]      rsp_count_ff;

   logic                  rd_en;
   logic [IDX_W-1:0]      rd_addr;
   logic [KEY_BITS-1:0]   rd_data;
   logic                  wr_en;
   logic [IDX_W-1:0]      wr_addr;
   logic [KEY_BITS-1:0]   wr_data;

   skt_ctrl #(
      .CAPACITY(CAPACITY),
      .KEY_BITS(KEY_BITS)
   ) u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .req_func(req_func),
      .req_key (req_key),
      .count   (count_ff),
      .busy    (busy),
      .done    (done),
      .done_pos(done_pos),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   skt_ram #(
      .WIDTH(KEY_BITS),
      .DEPTH(CAPACITY)
   ) u_key_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   always_comb begin
      count_in = count_ff;
      if (done.fire && done.inc) begin
         count_in = count_ff + 1'b1;
      end else if (done.fire && done.dec) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= done.fire;
      end
      if (done.fire) begin
         rsp_status_ff <= done.status;
         rsp_pos_ff    <= done_pos;
         rsp_count_ff  <= count_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_position    = skt_pkg::RSP_POS_W'(rsp_pos_ff);
   assign rsp_entry_count = skt_pkg::RSP_POS_W'(rsp_count_ff);

endmodule

`default_nettype wire

[sv/skt_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module skt_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[sv/skt_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

module skt_ctrl #(
   parameter int CAPACITY = skt_pkg::CAPACITY_DEFAULT,
   parameter int KEY_BITS = skt_pkg::KEY_BITS_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   input  wire logic [1:0]                        req_func,
   input  wire logic [skt_pkg::REQ_KEY_W-1:0]     req_key,
   input  wire logic [$clog2(CAPACITY+1)-1:0]     count,
   output logic                                   busy,
   output skt_pkg::skt_done_type                  done,
   output logic      [$clog2(CAPACITY+1)-1:0]     done_pos,
   output logic                                   rd_en,
   output logic      [$clog2(CAPACITY)-1:0]       rd_addr,
   input  wire logic [KEY_BITS-1:0]               rd_data,
   output logic                                   wr_en,
   output logic      [$clog2(CAPACITY)-1:0]       wr_addr,
   output logic      [KEY_BITS-1:0]               wr_data
);

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int IDX_W = $clog2(CAPACITY);

   typedef enum logic [5:0] {
      S_IDLE     = 6'b000001,
      S_SCAN_RD  = 6'b000010,
      S_SCAN_CMP = 6'b000100,
      S_SHIFT_RD = 6'b001000,
      S_SHIFT_WR = 6'b010000,
      S_PUT      = 6'b100000
   } state_type;

   state_type                  state_ff, state_in;
   logic [1:0]                 func_ff, func_in;
   logic signed [KEY_BITS-1:0] key_ff, key_in;
   logic [CNT_W-1:0]           idx_ff, idx_in;
   logic [CNT_W-1:0]           slot_ff, slot_in;
   logic [CNT_W-1:0]           idx_m1, idx_p1, idx_p2, slot_p1;
   logic                       resolve;
   logic                       found;

   assign idx_m1  = idx_ff - 1'b1;
   assign idx_p1  = idx_ff + 1'b1;
   assign idx_p2  = idx_ff + 2'd2;
   assign slot_p1 = slot_ff + 1'b1;
   assign busy    = (state_ff != S_IDLE);

   always_comb begin
      state_in    = state_ff;
      func_in     = func_ff;
      key_in      = key_ff;
      idx_in      = idx_ff;
      slot_in     = slot_ff;
      rd_en       = 1'b0;
      rd_addr     = idx_ff[IDX_W-1:0];
      wr_en       = 1'b0;
      wr_addr     = idx_ff[IDX_W-1:0];
      wr_data     = rd_data;
      done.fire   = 1'b0;
      done.status = skt_pkg::STATUS_OK;
      done.inc    = 1'b0;
      done.dec    = 1'b0;
      done_pos    = '0;
      resolve     = 1'b0;
      found       = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               func_in  = req_func;
               key_in   = KEY_BITS'($signed(req_key));
               idx_in   = '0;
               state_in = S_SCAN_RD;
            end
         end
         S_SCAN_RD: begin
            if (idx_ff == count) begin
               resolve = 1'b1;
            end else begin
               rd_en    = 1'b1;
               state_in = S_SCAN_CMP;
            end
         end
         S_SCAN_CMP: begin
            if ($signed(rd_data) < key_ff) begin
               idx_in   = idx_p1;
               state_in = S_SCAN_RD;
            end else begin
               resolve = 1'b1;
               found   = (rd_data == key_ff);
            end
         end
         S_SHIFT_RD: begin
            rd_en    = 1'b1;
            rd_addr  = (func_ff == skt_pkg::FUNC_INSERT) ? idx_m1[IDX_W-1:0]
                                                         : idx_p1[IDX_W-1:0];
            state_in = S_SHIFT_WR;
         end
         S_SHIFT_WR: begin
            wr_en = 1'b1;
            if (func_ff == skt_pkg::FUNC_INSERT) begin
               // move one entry up, walking down toward the slot
               idx_in   = idx_m1;
               state_in = (idx_m1 == slot_ff) ? S_PUT : S_SHIFT_RD;
            end else begin
               // close the gap, walking up toward the tail
               idx_in = idx_p1;
               if (idx_p2 == count) begin
                  done.fire   = 1'b1;
                  done.status = skt_pkg::STATUS_OK;
                  done.dec    = 1'b1;
                  done_pos    = slot_p1;
                  state_in    = S_IDLE;
               end else begin
                  state_in = S_SHIFT_RD;
               end
            end
         end
         S_PUT: begin
            wr_en       = 1'b1;
            wr_addr     = slot_ff[IDX_W-1:0];
            wr_data     = key_ff;
            done.fire   = 1'b1;
            done.status = skt_pkg::STATUS_OK;
            done.inc    = 1'b1;
            done_pos    = slot_p1;
            state_in    = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (resolve) begin
         slot_in  = idx_ff;
         state_in = S_IDLE;
         case (func_ff)
            skt_pkg::FUNC_INSERT: begin
               if (found) begin
                  done.fire   = 1'b1;
                  done.status = skt_pkg::STATUS_DUP;
                  done_pos    = idx_p1;
               end else if (count == CNT_W'(CAPACITY)) begin
                  done.fire   = 1'b1;
                  done.status = skt_pkg::STATUS_FULL;
               end else if (count == idx_ff) begin
                  state_in = S_PUT;
               end else begin
                  idx_in   = count;
                  state_in = S_SHIFT_RD;
               end
            end
            skt_pkg::FUNC_DELETE: begin
               if (count == '0) begin
                  done.fire   = 1'b1;
                  done.status = skt_pkg::STATUS_EMPTY;
               end else if (!found) begin
                  done.fire   = 1'b1;
                  done.status = skt_pkg::STATUS_NOTFOUND;
               end else if (idx_p1 == count) begin
                  done.fire   = 1'b1;
                  done.status = skt_pkg::STATUS_OK;
                  done.dec    = 1'b1;
                  done_pos    = idx_p1;
               end else begin
                  state_in = S_SHIFT_RD;
               end
            end
            skt_pkg::FUNC_SEARCH: begin
               done.fire = 1'b1;
               if (found) begin
                  done.status = skt_pkg::STATUS_OK;
                  done_pos    = idx_p1;
               end else begin
                  done.status = skt_pkg::STATUS_NOTFOUND;
               end
            end
            default: begin
               done.fire   = 1'b1;
               done.status = skt_pkg::STATUS_OK;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      func_ff <= func_in;
      key_ff  <= key_in;
      idx_ff  <= idx_in;
      slot_ff <= slot_in;
   end

endmodule

`default_nettype wire

[sv/skt_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

module skt_checker #(
   parameter int CAPACITY = skt_pkg::CAPACITY_DEFAULT
) (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          start,
   input wire logic                          busy,
   input wire logic                          rsp_valid,
   input wire logic [2:0]                    rsp_status,
   input wire logic [skt_pkg::RSP_POS_W-1:0] rsp_position,
   input wire logic [skt_pkg::RSP_POS_W-1:0] rsp_entry_count
);

   // a taken request keeps the block busy until it resolves
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("request accepted but busy did not rise");

   // one response per request, never two in a row
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("back-to-back responses");

   a_fail_no_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == skt_pkg::STATUS_FULL ||
                    rsp_status == skt_pkg::STATUS_NOTFOUND ||
                    rsp_status == skt_pkg::STATUS_EMPTY) |-> rsp_position == '0)
      else $error("failed request reports a position");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == skt_pkg::STATUS_FULL
      |-> rsp_entry_count == skt_pkg::RSP_POS_W'(CAPACITY))
      else $error("table full reported below capacity");

   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == skt_pkg::STATUS_EMPTY |-> rsp_entry_count == '0)
      else $error("table empty reported with keys held");

endmodule

bind sorted_key_table skt_checker #(
   .CAPACITY(CAPACITY)
) u_skt_checker (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .rsp_valid      (rsp_valid),
   .rsp_status     (rsp_status),
   .rsp_position   (rsp_position),
   .rsp_entry_count(rsp_entry_count)
);

`default_nettype wire

[bench/sorted_key_table_tb.sv]
`timescale 1ns / 1ps

module sorted_key_table_tb;

   localparam int CAPACITY       = 64;
   localparam int ITEM_TARGET    = 650;
   localparam int PHASE_ITEMS    = 100;
   localparam int SETTLE_CYCLES  = 300;
   localparam int CYCLE_LIMIT    = 1000000;
   localparam logic [1:0] FUNC_UNUSED = 2'd3;

   localparam int PHASE_FILL  = 0;
   localparam int PHASE_MIXED = 1;
   localparam int PHASE_DRAIN = 2;

   localparam logic signed [31:0] KEY_MIN = 32'sh8000_0000;
   localparam logic signed [31:0] KEY_MAX = 32'sh7FFF_FFFF;

   typedef struct packed {
      skt_pkg::skt_status_type status;
      logic [6:0]              position;
      logic [6:0]              entry_count;
   } table_reply_type;

   class key_table_scoreboard;
      logic signed [31:0] held_keys[$];
      table_reply_type    pending_replies[$];
      int                 failures = 0;

      // Work out the reply to one accepted request and update the held keys.
      function void predict_reply(logic [1:0] op, logic signed [31:0] k);
         int              slot;
         bit              found;
         table_reply_type r;
         slot = 0;
         while (slot < held_keys.size() && held_keys[slot] < k)
            slot++;
         found = (slot < held_keys.size()) && (held_keys[slot] == k);
         r.status   = skt_pkg::STATUS_OK;
         r.position = '0;
         case (op)
            skt_pkg::FUNC_INSERT: begin
               if (found) begin
                  r.status   = skt_pkg::STATUS_DUP;
                  r.position = 7'(slot + 1);
               end else if (held_keys.size() >= CAPACITY) begin
                  r.status = skt_pkg::STATUS_FULL;
               end else begin
                  held_keys.insert(slot, k);
                  r.position = 7'(slot + 1);
               end
            end
            skt_pkg::FUNC_DELETE: begin
               if (held_keys.size() == 0) begin
                  r.status = skt_pkg::STATUS_EMPTY;
               end else if (!found) begin
                  r.status = skt_pkg::STATUS_NOTFOUND;
               end else begin
                  held_keys.delete(slot);
                  r.position = 7'(slot + 1);
               end
            end
            skt_pkg::FUNC_SEARCH: begin
               if (found) r.position = 7'(slot + 1);
               else r.status = skt_pkg::STATUS_NOTFOUND;
            end
            default: ;
         endcase
         r.entry_count = 7'(held_keys.size());
         pending_replies.push_back(r);
      endfunction

      function void check_reply(logic [2:0] st, logic [6:0] pos, logic [6:0] cnt);
         table_reply_type want;
         if (pending_replies.size() == 0) begin
            $error("unexpected response: status %0d position %0d entry_count %0d",
                   st, pos, cnt);
            failures++;
            return;
         end
         want = pending_replies.pop_front();
         if (st !== want.status) begin
            $error("rsp_status expected %0d got %0d", want.status, st);
            failures++;
         end
         if (pos !== want.position) begin
            $error("rsp_position expected %0d got %0d", want.position, pos);
            failures++;
         end
         if (cnt !== want.entry_count) begin
            $error("rsp_entry_count expected %0d got %0d", want.entry_count, cnt);
            failures++;
         end
      endfunction
   endclass

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic [1:0]         req_func;
   logic signed [31:0] req_key;
   logic               rsp_valid;
   logic [2:0]         rsp_status;
   logic [6:0]         rsp_position;
   logic [6:0]         rsp_entry_count;

   key_table_scoreboard sb = new();
   int                  cycle_count = 0;
   int                  burst_left = 0;
   int                  items_sent = 0;

   sorted_key_table #(.CAPACITY(CAPACITY), .KEY_BITS(32)) uut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_func        (req_func),
      .req_key         (req_key),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_position    (rsp_position),
      .rsp_entry_count (rsp_entry_count)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid)
         sb.check_reply(rsp_status, rsp_position, rsp_entry_count);
   end

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic send_request(logic [1:0] op, logic signed [31:0] k);
      int gap;
      if (burst_left > 0) begin
         burst_left--;
         gap = 0;
      end else if ($urandom_range(0, 15) == 0) begin
         burst_left = $urandom_range(10, 40);
         gap = 0;
      end else begin
         gap = $urandom_range(0, 19);
      end
      if (gap > 0) begin
         start = 1'b0;
         repeat (gap) @(negedge clock);
      end
      start    = 1'b1;
      req_func = op;
      req_key  = k;
      do @(posedge clock); while (busy);
      sb.predict_reply(op, k);
      if (op != FUNC_UNUSED) items_sent++;
      @(negedge clock);
   endtask

   function automatic logic signed [31:0] extreme_key();
      case ($urandom_range(0, 3))
         0: return KEY_MIN;
         1: return KEY_MAX;
         2: return 32'sd0;
         default: return -32'sd1;
      endcase
   endfunction

   // Inserts mostly bring fresh keys; deletes and searches mostly hit held ones.
   function automatic logic signed [31:0] pick_key(logic [1:0] op);
      int r;
      int n;
      r = $urandom_range(0, 99);
      n = sb.held_keys.size();
      if (op == skt_pkg::FUNC_INSERT) begin
         if (n > 0 && r < 20) return sb.held_keys[$urandom_range(0, n - 1)];
         if (r < 30) return extreme_key();
         return $urandom;
      end
      if (n > 0 && r < 70) return sb.held_keys[$urandom_range(0, n - 1)];
      if (r < 80) return extreme_key();
      return $urandom;
   endfunction

   function automatic logic [1:0] pick_op(int phase);
      int r;
      r = $urandom_range(0, 99);
      case (phase)
         PHASE_FILL: begin
            if (r < 80) return skt_pkg::FUNC_INSERT;
            if (r < 88) return skt_pkg::FUNC_DELETE;
            if (r < 98) return skt_pkg::FUNC_SEARCH;
         end
         PHASE_DRAIN: begin
            if (r < 75) return skt_pkg::FUNC_DELETE;
            if (r < 85) return skt_pkg::FUNC_INSERT;
            if (r < 98) return skt_pkg::FUNC_SEARCH;
         end
         default: begin
            if (r < 40) return skt_pkg::FUNC_INSERT;
            if (r < 70) return skt_pkg::FUNC_DELETE;
            if (r < 97) return skt_pkg::FUNC_SEARCH;
         end
      endcase
      return FUNC_UNUSED;
   endfunction

   initial begin
      int         phase;
      int         phase_end;
      int         settle;
      logic [1:0] op;
      reset    = 1'b1;
      start    = 1'b0;
      req_func = skt_pkg::FUNC_INSERT;
      req_key  = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: empty table, extremes, duplicates, misses, unused selector.
      send_request(skt_pkg::FUNC_SEARCH, 32'sd5);
      send_request(skt_pkg::FUNC_DELETE, 32'sd5);
      send_request(skt_pkg::FUNC_INSERT, 32'sd0);
      send_request(skt_pkg::FUNC_INSERT, KEY_MAX);
      send_request(skt_pkg::FUNC_INSERT, KEY_MIN);
      send_request(skt_pkg::FUNC_INSERT, -32'sd1);
      send_request(skt_pkg::FUNC_INSERT, 32'sd1);
      send_request(skt_pkg::FUNC_INSERT, 32'sd0);
      send_request(skt_pkg::FUNC_INSERT, KEY_MAX);
      send_request(skt_pkg::FUNC_SEARCH, KEY_MIN);
      send_request(skt_pkg::FUNC_SEARCH, KEY_MAX);
      send_request(skt_pkg::FUNC_SEARCH, 32'sd7);
      send_request(FUNC_UNUSED, 32'shAAAA_AAAA);
      send_request(skt_pkg::FUNC_DELETE, 32'sd7);
      send_request(skt_pkg::FUNC_DELETE, 32'sd0);
      send_request(skt_pkg::FUNC_DELETE, KEY_MIN);
      send_request(skt_pkg::FUNC_DELETE, KEY_MAX);
      send_request(skt_pkg::FUNC_DELETE, -32'sd1);
      send_request(skt_pkg::FUNC_DELETE, 32'sd1);
      send_request(skt_pkg::FUNC_DELETE, 32'sd1);
      send_request(skt_pkg::FUNC_SEARCH, 32'sd1);
      send_request(FUNC_UNUSED, 32'sh5555_5555);

      // Random: cycle through fill, mixed and drain phases.
      phase = PHASE_FILL;
      while (items_sent < ITEM_TARGET) begin
         phase_end = items_sent + PHASE_ITEMS;
         while (items_sent < phase_end && items_sent < ITEM_TARGET) begin
            op = pick_op(phase);
            send_request(op, pick_key(op));
         end
         case (phase)
            PHASE_FILL:  phase = PHASE_MIXED;
            PHASE_MIXED: phase = (sb.held_keys.size() > CAPACITY / 2) ? PHASE_DRAIN
                                                                       : PHASE_FILL;
            default:     phase = PHASE_MIXED;
         endcase
      end
      start = 1'b0;

      while (sb.pending_replies.size() != 0) @(posedge clock);
      settle = SETTLE_CYCLES;
      repeat (settle) @(posedge clock);

      if (sb.failures == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
